// ===== rtl/rfla_pkg.sv =====
package rfla_pkg;

    localparam int FREE_ENTRIES_DEF    = 64;
    localparam int MAX_DESCRIPTORS_DEF = 65536;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_DESC_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESC_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE    = 2'd3;

    localparam logic       MODE_FREE    = 1'b1;

    localparam logic [2:0] ST_EXACT     = 3'd0;
    localparam logic [2:0] ST_TAIL      = 3'd1;
    localparam logic [2:0] ST_SPLIT     = 3'd2;
    localparam logic [2:0] ST_NO_SPACE  = 3'd3;
    localparam logic [2:0] ST_FREED     = 3'd4;
    localparam logic [2:0] ST_LIST_FULL = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [16:0] request_count;
        logic [15:0] free_start;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] start_index;
        logic [16:0] granted_count;
        logic [63:0] cpu_address;
        logic [63:0] gpu_address;
    } t_rsp;

    typedef struct packed {
        logic [16:0] descriptor_total;
        logic [12:0] descriptor_stride;
        logic [63:0] cpu_base_address;
        logic [63:0] gpu_base_address;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic select;
        logic shift;
        logic shrink;
        logic mul;
        logic add;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic count_zero;
        logic pass_done;
        logic exact_hit;
    } t_sts;

endpackage

// ===== rtl/rfla_ctrl.sv =====
module rfla_ctrl import rfla_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_done
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_SELECT = 8'b0000_1000,
        S_SHIFT  = 8'b0001_0000,
        S_MUL    = 8'b0010_0000,
        S_ADD    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.is_free || i_sts.count_zero) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.pass_done) begin
                    n_state = S_SELECT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_SELECT: begin
                o_cmd.select = 1'b1;
                if (i_sts.exact_hit) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SHIFT: begin
                if (i_sts.pass_done) begin
                    o_cmd.shrink = 1'b1;
                    n_state      = S_MUL;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ===== rtl/rfla_dp.sv =====
module rfla_dp import rfla_pkg::*; #(
    parameter int FREE_ENTRIES    = FREE_ENTRIES_DEF,
    parameter int MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_sts o_sts,
    output t_rsp o_rsp
);

    localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CW = $clog2(FREE_ENTRIES + 1);

    logic [32:0]   r_mem [FREE_ENTRIES];
    logic [32:0]   r_rd_data;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_total;
    logic [16:0]   r_tail;

    logic          r_mode;
    logic [16:0]   r_count;
    logic [15:0]   r_fstart;

    logic          r_exact_hit;
    logic [IW-1:0] r_exact_idx;
    logic [15:0]   r_exact_start;
    logic          r_fit_hit;
    logic [IW-1:0] r_fit_idx;
    logic [15:0]   r_fit_start;
    logic [16:0]   r_fit_size;

    logic [2:0]    r_res_status;
    logic [15:0]   r_res_start;
    logic [16:0]   r_res_count;
    logic [28:0]   r_prod;
    t_rsp          r_rsp;

    logic          w_issue;
    logic          w_pass_done;
    logic          w_full;
    logic          w_count_zero;
    logic          w_append;
    logic          w_tail_fits;
    logic [16:0]   w_heap;
    logic [16:0]   w_fit_sum;
    logic [15:0]   w_rd_start;
    logic [16:0]   w_rd_size;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    logic [32:0]   w_wr_data;

    assign w_pass_done  = (r_idx == r_total) && !r_rd_vld;
    assign w_issue      = (i_cmd.scan || i_cmd.shift) && (r_idx != r_total);
    assign w_full       = (r_total >= CW'(FREE_ENTRIES));
    assign w_count_zero = (r_count == 17'd0);
    assign w_append     = (r_mode == MODE_FREE) && !w_count_zero && !w_full;
    assign w_rd_start   = r_rd_data[32:17];
    assign w_rd_size    = r_rd_data[16:0];
    assign w_fit_sum    = {1'b0, r_fit_start} + r_count;

    always_comb begin
        if ({15'd0, i_cfg.descriptor_total} > 32'(MAX_DESCRIPTORS)) begin
            w_heap = 17'(MAX_DESCRIPTORS);
        end else begin
            w_heap = i_cfg.descriptor_total;
        end
    end

    assign w_tail_fits = (r_tail <= w_heap) && (r_count <= (w_heap - r_tail));

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = '0;
        if (i_cmd.check && w_append) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_total[IW-1:0];
            w_wr_data = {r_fstart, r_count};
        end else if (i_cmd.select && !r_exact_hit && !w_tail_fits && r_fit_hit) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_fit_idx;
            w_wr_data = {w_fit_sum[15:0], r_fit_size - r_count};
        end else if (i_cmd.shift && r_rd_vld) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_rd_idx - IW'(1);
            w_wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_tail      <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_exact_hit <= 1'b0;
            r_fit_hit   <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.check) begin
                r_idx       <= '0;
                r_exact_hit <= 1'b0;
                r_fit_hit   <= 1'b0;
                if (w_append) begin
                    r_total <= r_total + CW'(1);
                end
            end
            if (i_cmd.scan && r_rd_vld) begin
                if (!r_exact_hit && (w_rd_size == r_count)) begin
                    r_exact_hit <= 1'b1;
                end
                if (!r_fit_hit && (w_rd_size >= r_count)) begin
                    r_fit_hit <= 1'b1;
                end
            end
            if (i_cmd.select) begin
                if (r_exact_hit) begin
                    r_idx <= CW'(r_exact_idx) + CW'(1);
                end else if (w_tail_fits) begin
                    r_tail <= r_tail + r_count;
                end
            end
            if (i_cmd.shrink) begin
                r_total <= r_total - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[IW-1:0];
        if (i_cmd.load) begin
            r_mode   <= i_req.mode;
            r_count  <= i_req.request_count;
            r_fstart <= i_req.free_start;
        end
        if (i_cmd.scan && r_rd_vld) begin
            if (!r_exact_hit && (w_rd_size == r_count)) begin
                r_exact_idx   <= r_rd_idx;
                r_exact_start <= w_rd_start;
            end
            if (!r_fit_hit && (w_rd_size >= r_count)) begin
                r_fit_idx   <= r_rd_idx;
                r_fit_start <= w_rd_start;
                r_fit_size  <= w_rd_size;
            end
        end
        if (i_cmd.check) begin
            r_res_start <= '0;
            r_res_count <= '0;
            if (r_mode == MODE_FREE) begin
                r_res_status <= (!w_count_zero && w_full) ? ST_LIST_FULL : ST_FREED;
            end else begin
                r_res_status <= ST_NO_SPACE;
            end
        end
        if (i_cmd.select) begin
            if (r_exact_hit) begin
                r_res_status <= ST_EXACT;
                r_res_start  <= r_exact_start;
                r_res_count  <= r_count;
            end else if (w_tail_fits) begin
                r_res_status <= ST_TAIL;
                r_res_start  <= r_tail[15:0];
                r_res_count  <= r_count;
            end else if (r_fit_hit) begin
                r_res_status <= ST_SPLIT;
                r_res_start  <= r_fit_start;
                r_res_count  <= r_count;
            end else begin
                r_res_status <= ST_NO_SPACE;
                r_res_start  <= '0;
                r_res_count  <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= 29'(r_res_start) * 29'(i_cfg.descriptor_stride);
        end
        if (i_cmd.add) begin
            r_rsp.status        <= r_res_status;
            r_rsp.start_index   <= r_res_start;
            r_rsp.granted_count <= r_res_count;
            if (r_res_count != 17'd0) begin
                r_rsp.cpu_address <= i_cfg.cpu_base_address + 64'(r_prod);
                r_rsp.gpu_address <= i_cfg.gpu_base_address + 64'(r_prod);
            end else begin
                r_rsp.cpu_address <= '0;
                r_rsp.gpu_address <= '0;
            end
        end
    end

    assign o_sts.is_free    = (r_mode == MODE_FREE);
    assign o_sts.count_zero = w_count_zero;
    assign o_sts.pass_done  = w_pass_done;
    assign o_sts.exact_hit  = r_exact_hit;
    assign o_rsp            = r_rsp;

endmodule

// ===== rtl/range_free_list_allocator_unit.sv =====
// A free request or a zero-size allocate goes from the check state straight to the multiply,
// add and done states, with o_done high in the done state. Other allocates first scan the
// free list entries, then select a range, and remove an exact match at entry k by moving
// the entries after it down one place. The free list memory has a single read port and is
// scanned and compacted one entry a cycle.
// One transaction is in flight at a time; start is taken again the cycle after o_done.
// Synchronous active-low reset empties the free list and tail and restores config defaults.
module range_free_list_allocator_unit import rfla_pkg::*; #(
    parameter int FREE_ENTRIES    = FREE_ENTRIES_DEF,
    parameter int MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_req                  i_req,
    output logic                  o_done,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.descriptor_total  <= 17'd0;
            r_cfg.descriptor_stride <= 13'd32;
            r_cfg.cpu_base_address  <= 64'd0;
            r_cfg.gpu_base_address  <= 64'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DESC_TOTAL:  r_cfg.descriptor_total  <= i_cfg_wdata[16:0];
                CFG_DESC_STRIDE: r_cfg.descriptor_stride <= i_cfg_wdata[12:0];
                CFG_CPU_BASE:    r_cfg.cpu_base_address  <= i_cfg_wdata;
                CFG_GPU_BASE:    r_cfg.gpu_base_address  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    rfla_dp #(
        .FREE_ENTRIES    (FREE_ENTRIES),
        .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("Result strobe lasted more than one cycle.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done))
        else $error("Accepted transaction did not keep the unit busy.");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.granted_count == 17'd0)) |->
        ((o_rsp.cpu_address == 64'd0) && (o_rsp.gpu_address == 64'd0)))
        else $error("Empty grant carries a nonzero address.");

    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_rsp.status == ST_NO_SPACE) || (o_rsp.status == ST_FREED) ||
                    (o_rsp.status == ST_LIST_FULL))) |->
        ((o_rsp.granted_count == 17'd0) && (o_rsp.start_index == 16'd0)))
        else $error("Failed or free transaction reports a granted range.");

endmodule
